// ----- sv/sbf_pkg.sv -----
`timescale 1ns / 1ps
package sbf_pkg;

	localparam int MAX_WIDTH_DEF       = 1024;
	localparam int PIXEL_BITS_DEF      = 16;
	localparam int EXTRA_FRAC_BITS_DEF = 4;

	localparam int JQ_DEPTH      = 4;
	localparam int OQ_DEPTH      = 8;
	localparam int ROW_BITS      = 16;
	localparam int IW_BITS       = 11;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [IW_BITS-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [ROW_BITS-1:0] HEIGHT_RESET = 16'd480;

	typedef enum logic {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                     valid;
		cfg_reg_t                 index;
		logic [CFG_DATA_BITS-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [ROW_BITS-1:0] row;
		logic                last_row;
		logic                done;
	} job_tag_t;

	typedef struct packed {
		logic [ROW_BITS-1:0] row;
		logic                done;
	} out_tag_t;

endpackage

// ----- sv/sbf_fifo.sv -----
`timescale 1ns / 1ps
module sbf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push0,
	input  logic             push1,
	input  logic [WIDTH-1:0] din0,
	input  logic [WIDTH-1:0] din1,
	output logic             ready,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = PW + 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    count_q;
	logic             do_pop;

	// ready means room for two entries
	assign ready  = count_q <= CW'(DEPTH - 2);
	assign empty  = count_q == '0;
	assign dout   = slot_q[rd_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PW'(push0) + PW'(push1);
			rd_q    <= rd_q + PW'(do_pop);
			count_q <= count_q + CW'(push0) + CW'(push1) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push0)
			slot_q[wr_q] <= din0;
		if (push1)
			slot_q[wr_q + PW'(1)] <= din1;
	end

endmodule

// ----- sv/sbf_front.sv -----
`timescale 1ns / 1ps
module sbf_front
	import sbf_pkg::*;
#(
	parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS      = PIXEL_BITS_DEF,
	parameter int EXTRA_FRAC_BITS = EXTRA_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cfg_wr_t                               cfg,
	input  logic                                  push,
	output logic                                  full,
	input  logic [PIXEL_BITS-1:0]                 pixel_in,
	input  logic                                  jq_ready,
	output logic                                  jq_push0,
	output logic                                  jq_push1,
	output logic [PIXEL_BITS+EXTRA_FRAC_BITS-1:0] job0_val,
	output logic [$clog2(MAX_WIDTH)-1:0]          job0_col,
	output job_tag_t                              job0_tag,
	output logic [PIXEL_BITS+EXTRA_FRAC_BITS-1:0] job1_val,
	output logic [$clog2(MAX_WIDTH)-1:0]          job1_col,
	output job_tag_t                              job1_tag
);

	localparam int P  = PIXEL_BITS;
	localparam int E  = EXTRA_FRAC_BITS;
	localparam int HW = P + E;
	localparam int CB = $clog2(MAX_WIDTH);
	localparam int WB = (CB + 1 > IW_BITS) ? CB + 1 : IW_BITS;
	localparam int XW = P + 2;
	localparam int K  = P + 4;
	localparam int MW = 2 * P + 5;
	localparam logic [K:0]     POW   = {1'b1, {K{1'b0}}};
	localparam logic [P+2:0]   RECIP = (P + 3)'(POW / 3 + 1);
	localparam logic [HW-1:0]  THIRD1 = HW'((1 << E) / 3);
	localparam logic [HW-1:0]  THIRD2 = HW'((2 << E) / 3);

	logic [IW_BITS-1:0]  width_q;
	logic [ROW_BITS-1:0] height_q;
	logic [WB-1:0]       width_ext;
	logic [CB-1:0]       col_last;
	logic [ROW_BITS-1:0] row_last;

	logic [CB-1:0]       col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [P-1:0]        prev_q;
	logic [P-1:0]        pprev_q;
	logic                last_col;
	logic                last_row;
	logic                accept;
	logic                adv;

	logic                v_s1;
	logic [P-1:0]        cur_s1;
	logic [P-1:0]        prev_s1;
	logic [P-1:0]        pprev_s1;
	logic [CB-1:0]       col_s1;
	logic [ROW_BITS-1:0] row_s1;
	logic                lc_s1;
	logic                lr_s1;

	logic [XW-1:0]       xa;
	logic [XW-1:0]       xb;
	logic [XW-1:0]       sum3;
	logic [XW+E-1:0]     sum3_wide;
	logic [MW-1:0]       prod_a;
	logic [MW-1:0]       prod_b;

	logic                v_s2;
	logic [MW-1:0]       prod_a_s2;
	logic [MW-1:0]       prod_b_s2;
	logic [XW-1:0]       xa_s2;
	logic [XW-1:0]       xb_s2;
	logic [HW-1:0]       hsum_s2;
	logic [CB-1:0]       col_s2;
	logic [ROW_BITS-1:0] row_s2;
	logic                lc_s2;
	logic                lr_s2;
	logic                ja_s2;
	logic                one_s2;

	logic [XW-1:0]       qa;
	logic [XW-1:0]       qb;
	logic [1:0]          ra;
	logic [1:0]          rb;
	logic [HW-1:0]       fa;
	logic [HW-1:0]       fb;
	logic [HW-1:0]       hv_a;
	logic [HW-1:0]       hv_b;
	logic                fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_WIDTH:  width_q  <= cfg.data[IW_BITS-1:0];
				CFG_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign width_ext = WB'(width_q);

	always_comb begin
		if (width_ext < WB'(2))
			col_last = CB'(1);
		else if (width_ext > WB'(MAX_WIDTH))
			col_last = CB'(MAX_WIDTH - 1);
		else
			col_last = CB'(width_ext - WB'(1));
	end

	assign row_last = (height_q < ROW_BITS'(2)) ? ROW_BITS'(1) : height_q - ROW_BITS'(1);
	assign last_col = col_q >= col_last;
	assign last_row = row_q >= row_last;

	assign adv    = !v_s2 || jq_ready;
	assign full   = v_s1 && !adv;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			prev_q  <= '0;
			pprev_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q   <= '0;
				prev_q  <= '0;
				pprev_q <= '0;
				row_q   <= last_row ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q   <= col_q + CB'(1);
				prev_q  <= pixel_in;
				pprev_q <= prev_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv || !v_s1)
				v_s1 <= accept;
			if (adv)
				v_s2 <= v_s1;
		end
	end

	// weighted row sums and the reciprocal products for the edge case
	assign xa        = {1'b0, prev_s1, 1'b0} + XW'(cur_s1);
	assign xb        = XW'(prev_s1) + {1'b0, cur_s1, 1'b0};
	assign sum3      = xa + XW'(pprev_s1);
	assign sum3_wide = (XW + E)'(sum3) << E;
	assign prod_a    = MW'(xa) * MW'(RECIP);
	assign prod_b    = MW'(xb) * MW'(RECIP);

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1   <= pixel_in;
			prev_s1  <= prev_q;
			pprev_s1 <= pprev_q;
			col_s1   <= col_q;
			row_s1   <= row_q;
			lc_s1    <= last_col;
			lr_s1    <= last_row;
		end
		if (adv && v_s1) begin
			prod_a_s2 <= prod_a;
			prod_b_s2 <= prod_b;
			xa_s2     <= xa;
			xb_s2     <= xb;
			hsum_s2   <= HW'(sum3_wide >> 2);
			col_s2    <= col_s1;
			row_s2    <= row_s1;
			lc_s2     <= lc_s1;
			lr_s2     <= lr_s1;
			ja_s2     <= col_s1 != '0;
			one_s2    <= col_s1 == CB'(1);
		end
	end

	// exact divide by three: quotient from the product, fraction from the remainder
	assign qa = XW'(prod_a_s2 >> K);
	assign qb = XW'(prod_b_s2 >> K);
	assign ra = 2'(xa_s2 - (qa << 1) - qa);
	assign rb = 2'(xb_s2 - (qb << 1) - qb);

	always_comb begin
		case (ra)
			2'd1:    fa = THIRD1;
			2'd2:    fa = THIRD2;
			default: fa = '0;
		endcase
		case (rb)
			2'd1:    fb = THIRD1;
			2'd2:    fb = THIRD2;
			default: fb = '0;
		endcase
	end

	assign hv_a = one_s2 ? (HW'(qa) << E) + fa : hsum_s2;
	assign hv_b = (HW'(qb) << E) + fb;

	assign fire     = v_s2 && jq_ready;
	assign jq_push0 = fire && (ja_s2 || lc_s2);
	assign jq_push1 = fire && ja_s2 && lc_s2;

	always_comb begin
		job1_val = hv_b;
		job1_col = col_s2;
		job1_tag = '{row: row_s2, last_row: lr_s2, done: lr_s2};
		if (ja_s2) begin
			job0_val = hv_a;
			job0_col = col_s2 - CB'(1);
			job0_tag = '{row: row_s2, last_row: lr_s2, done: 1'b0};
		end else begin
			job0_val = job1_val;
			job0_col = job1_col;
			job0_tag = job1_tag;
		end
	end

endmodule

// ----- sv/sbf_back.sv -----
`timescale 1ns / 1ps
module sbf_back
	import sbf_pkg::*;
#(
	parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS      = PIXEL_BITS_DEF,
	parameter int EXTRA_FRAC_BITS = EXTRA_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  jq_empty,
	output logic                                  jq_pop,
	input  logic [PIXEL_BITS+EXTRA_FRAC_BITS-1:0] job_val,
	input  logic [$clog2(MAX_WIDTH)-1:0]          job_col,
	input  job_tag_t                              job_tag,
	input  logic                                  oq_ready,
	output logic                                  oq_push0,
	output logic                                  oq_push1,
	output logic [PIXEL_BITS-1:0]                 out0_pix,
	output out_tag_t                              out0_tag,
	output logic [PIXEL_BITS-1:0]                 out1_pix,
	output out_tag_t                              out1_tag,
	output logic [$clog2(MAX_WIDTH)-1:0]          out_col
);

	localparam int P  = PIXEL_BITS;
	localparam int E  = EXTRA_FRAC_BITS;
	localparam int HW = P + E;
	localparam int CB = $clog2(MAX_WIDTH);
	localparam int YW = HW + 3;
	localparam int ZW = P + 3;
	localparam int K  = P + 5;
	localparam int MW = 2 * P + 7;
	localparam logic [K:0]    POW   = {1'b1, {K{1'b0}}};
	localparam logic [P+3:0]  RECIP = (P + 4)'(POW / 3 + 1);
	localparam logic [YW-1:0] HALF3 = YW'((3 << E) >> 1);
	localparam logic [YW-1:0] HALF4 = YW'(1 << (E + 1));

	logic [2*HW-1:0] line_mem [MAX_WIDTH];

	logic                adv;

	logic                v_s1;
	logic [2*HW-1:0]     line_s1;
	logic [HW-1:0]       h_s1;
	logic [CB-1:0]       col_s1;
	job_tag_t            tag_s1;

	logic [HW-1:0]       older;
	logic [HW-1:0]       newer;
	logic                first;
	logic [YW-1:0]       sa;
	logic [YW-1:0]       ya;
	logic [YW-1:0]       yb;
	logic [ZW-1:0]       za;
	logic [ZW-1:0]       zb;

	logic                v_s2;
	logic [ZW-1:0]       za_s2;
	logic [ZW-1:0]       zb_s2;
	logic                a3_s2;
	logic                ea_s2;
	logic                eb_s2;
	logic [CB-1:0]       col_s2;
	job_tag_t            tag_s2;
	logic [MW-1:0]       prod_a;
	logic [MW-1:0]       prod_b;

	logic                v_s3;
	logic [ZW-1:0]       qa_s3;
	logic [ZW-1:0]       qb_s3;
	logic                ea_s3;
	logic                eb_s3;
	logic [CB-1:0]       col_s3;
	job_tag_t            tag_s3;
	logic [P-1:0]        pa;
	logic [P-1:0]        pb;
	logic                fire;

	assign adv    = !v_s3 || oq_ready;
	assign jq_pop = adv && !jq_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !jq_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// each entry holds the two previous row values of its column
	always_ff @(posedge clk) begin
		if (jq_pop)
			line_s1 <= line_mem[job_col];
		if (adv && v_s1)
			line_mem[col_s1] <= {newer, h_s1};
	end

	assign older = line_s1[2*HW-1:HW];
	assign newer = line_s1[HW-1:0];
	assign first = tag_s1.row == ROW_BITS'(1);

	always_comb begin
		if (first)
			sa = {2'b0, newer, 1'b0} + YW'(h_s1);
		else
			sa = YW'(older) + {2'b0, newer, 1'b0} + YW'(h_s1);
	end

	assign ya = sa + (first ? HALF3 : HALF4);
	assign za = first ? ZW'(ya >> E) : ZW'(ya >> (E + 2));
	assign yb = YW'(newer) + {2'b0, h_s1, 1'b0} + HALF3;
	assign zb = ZW'(yb >> E);

	assign prod_a = MW'(za_s2) * MW'(RECIP);
	assign prod_b = MW'(zb_s2) * MW'(RECIP);

	always_ff @(posedge clk) begin
		if (jq_pop) begin
			h_s1   <= job_val;
			col_s1 <= job_col;
			tag_s1 <= job_tag;
		end
		if (adv && v_s1) begin
			za_s2  <= za;
			zb_s2  <= zb;
			a3_s2  <= first;
			ea_s2  <= tag_s1.row != '0;
			eb_s2  <= tag_s1.last_row;
			col_s2 <= col_s1;
			tag_s2 <= tag_s1;
		end
		if (adv && v_s2) begin
			qa_s3  <= a3_s2 ? ZW'(prod_a >> K) : za_s2;
			qb_s3  <= ZW'(prod_b >> K);
			ea_s3  <= ea_s2;
			eb_s3  <= eb_s2;
			col_s3 <= col_s2;
			tag_s3 <= tag_s2;
		end
	end

	// saturate to the pixel range
	assign pa = (|qa_s3[ZW-1:P]) ? '1 : qa_s3[P-1:0];
	assign pb = (|qb_s3[ZW-1:P]) ? '1 : qb_s3[P-1:0];

	assign fire     = v_s3 && oq_ready;
	assign oq_push0 = fire && (ea_s3 || eb_s3);
	assign oq_push1 = fire && ea_s3 && eb_s3;
	assign out_col  = col_s3;

	always_comb begin
		out1_pix = pb;
		out1_tag = '{row: tag_s3.row, done: tag_s3.done};
		if (ea_s3) begin
			out0_pix = pa;
			out0_tag = '{row: tag_s3.row - ROW_BITS'(1), done: 1'b0};
		end else begin
			out0_pix = out1_pix;
			out0_tag = out1_tag;
		end
	end

endmodule

// ----- sv/separable_121_smoothing_filter.sv -----
`timescale 1ns / 1ps
// Throughput: one pixel per cycle on every row but the last, unless the output is held;
// there each pixel yields two results while one leaves per cycle, so full throttles input.
// Path: when both queues are empty, a result passes front stages s1 and s2, the job queue,
// back stages s1, s2 and s3 and the output queue before it shows at the outputs.
// Reset: arst_n clears the position counters, pipelines and queues; the line buffers
// are not cleared and hold stale data until rows are written.
module separable_121_smoothing_filter
	import sbf_pkg::*;
#(
	parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS      = PIXEL_BITS_DEF,
	parameter int EXTRA_FRAC_BITS = EXTRA_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [0:0]                   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                         push,
	output logic                         full,
	input  logic [PIXEL_BITS-1:0]        pixel_in,
	output logic                         empty,
	input  logic                         pop,
	output logic [PIXEL_BITS-1:0]        pixel_out,
	output logic [$clog2(MAX_WIDTH)-1:0] out_column,
	output logic [ROW_BITS-1:0]          out_row,
	output logic                         image_done
);

	localparam int HW = PIXEL_BITS + EXTRA_FRAC_BITS;
	localparam int CB = $clog2(MAX_WIDTH);
	localparam int JW = HW + CB + $bits(job_tag_t);
	localparam int OW = PIXEL_BITS + CB + $bits(out_tag_t);

	cfg_wr_t             cfg_wr;

	logic                jq_push0;
	logic                jq_push1;
	logic                jq_ready;
	logic                jq_pop;
	logic                jq_empty;
	logic [HW-1:0]       job0_val;
	logic [CB-1:0]       job0_col;
	job_tag_t            job0_tag;
	logic [HW-1:0]       job1_val;
	logic [CB-1:0]       job1_col;
	job_tag_t            job1_tag;
	logic [JW-1:0]       jq_dout;
	logic [HW-1:0]       job_val;
	logic [CB-1:0]       job_col;
	job_tag_t            job_tag;

	logic                oq_push0;
	logic                oq_push1;
	logic                oq_ready;
	logic [PIXEL_BITS-1:0] out0_pix;
	out_tag_t            out0_tag;
	logic [PIXEL_BITS-1:0] out1_pix;
	out_tag_t            out1_tag;
	logic [CB-1:0]       res_col;
	logic [OW-1:0]       oq_dout;
	out_tag_t            head_tag;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_reg_t'(cfg_index);
	assign cfg_wr.data  = cfg_data;

	sbf_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS),
		.EXTRA_FRAC_BITS(EXTRA_FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_wr),
		.push(push),
		.full(full),
		.pixel_in(pixel_in),
		.jq_ready(jq_ready),
		.jq_push0(jq_push0),
		.jq_push1(jq_push1),
		.job0_val(job0_val),
		.job0_col(job0_col),
		.job0_tag(job0_tag),
		.job1_val(job1_val),
		.job1_col(job1_col),
		.job1_tag(job1_tag)
	);

	sbf_fifo #(
		.WIDTH(JW),
		.DEPTH(JQ_DEPTH)
	) u_job_q (
		.clk(clk),
		.arst_n(arst_n),
		.push0(jq_push0),
		.push1(jq_push1),
		.din0({job0_val, job0_col, job0_tag}),
		.din1({job1_val, job1_col, job1_tag}),
		.ready(jq_ready),
		.pop(jq_pop),
		.empty(jq_empty),
		.dout(jq_dout)
	);

	assign {job_val, job_col, job_tag} = jq_dout;

	sbf_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS),
		.EXTRA_FRAC_BITS(EXTRA_FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.jq_empty(jq_empty),
		.jq_pop(jq_pop),
		.job_val(job_val),
		.job_col(job_col),
		.job_tag(job_tag),
		.oq_ready(oq_ready),
		.oq_push0(oq_push0),
		.oq_push1(oq_push1),
		.out0_pix(out0_pix),
		.out0_tag(out0_tag),
		.out1_pix(out1_pix),
		.out1_tag(out1_tag),
		.out_col(res_col)
	);

	sbf_fifo #(
		.WIDTH(OW),
		.DEPTH(OQ_DEPTH)
	) u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.push0(oq_push0),
		.push1(oq_push1),
		.din0({out0_pix, res_col, out0_tag}),
		.din1({out1_pix, res_col, out1_tag}),
		.ready(oq_ready),
		.pop(pop),
		.empty(empty),
		.dout(oq_dout)
	);

	assign {pixel_out, out_column, head_tag} = oq_dout;
	assign out_row    = head_tag.row;
	assign image_done = head_tag.done;

	a_jq_room: assert property (@(posedge clk) disable iff (!arst_n)
		(jq_push0 || jq_push1) |-> jq_ready)
		else $error("job queue written without room");

	a_oq_room: assert property (@(posedge clk) disable iff (!arst_n)
		(oq_push0 || oq_push1) |-> oq_ready)
		else $error("result queue written without room");

	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !jq_ready)
		else $error("input stalled while job queue has room");

	a_done_row: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && image_done) |-> (out_row != '0))
		else $error("end of image flagged on the first row");

endmodule

// ----- tb/separable_121_smoothing_filter_tb.sv -----
`timescale 1ns / 1ps
module separable_121_smoothing_filter_tb;
	import sbf_pkg::*;

	localparam int MAX_W         = MAX_WIDTH_DEF;
	localparam int PIX_BITS      = PIXEL_BITS_DEF;
	localparam int FRAC          = EXTRA_FRAC_BITS_DEF;
	localparam int HROW_BITS     = PIX_BITS + FRAC;
	localparam int COL_BITS      = $clog2(MAX_W);
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RAND_PIXELS   = 130;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic [PIX_BITS-1:0] pixel;
		logic [COL_BITS-1:0] column;
		logic [ROW_BITS-1:0] row;
		logic                done;
	} blur_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [0:0]               cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     push;
	logic                     full;
	logic [PIX_BITS-1:0]      pixel_in;
	logic                     empty;
	logic                     pop;
	logic [PIX_BITS-1:0]      pixel_out;
	logic [COL_BITS-1:0]      out_column;
	logic [ROW_BITS-1:0]      out_row;
	logic                     image_done;

	// filtered pixels still owed by the block, oldest first
	blur_result_t pending_pixels[$];

	// predictor state
	logic [HROW_BITS-1:0] hrow_older [MAX_W];
	logic [HROW_BITS-1:0] hrow_newer [MAX_W];
	longint unsigned      prev_px;
	longint unsigned      prev2_px;
	int unsigned          col_pos;
	int unsigned          row_pos;
	logic [IW_BITS-1:0]   width_reg;
	logic [ROW_BITS-1:0]  height_reg;
	bit                   frame_closed;

	bit gaps_on;
	bit stalls_on;
	int rx_hold_cycles;
	int cycle_count;
	int pixels_sent;
	int results_checked;
	int images_done;
	int mismatches;
	int full_stalls;

	separable_121_smoothing_filter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.pixel_in   (pixel_in),
		.empty      (empty),
		.pop        (pop),
		.pixel_out  (pixel_out),
		.out_column (out_column),
		.out_row    (out_row),
		.image_done (image_done)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [PIX_BITS-1:0] round_scale(longint unsigned sum,
			longint unsigned divisor);
		longint unsigned d;
		longint unsigned v;
		d = divisor << FRAC;
		v = (sum + (d >> 1)) / d;
		return (v > 64'hFFFF) ? 16'hFFFF : v[PIX_BITS-1:0];
	endfunction

	// vertical pass over one column once its row value is known
	function automatic void take_hval(longint unsigned hv, int unsigned col, bit last_row,
			bit last_img);
		int unsigned     c;
		longint unsigned newer;
		longint unsigned older;
		blur_result_t    r;
		c = (col < MAX_W) ? col : MAX_W - 1;
		newer = hrow_newer[c];
		older = hrow_older[c];
		if (row_pos >= 1) begin
			if (row_pos == 1)
				r.pixel = round_scale(2 * newer + hv, 3);
			else
				r.pixel = round_scale(older + 2 * newer + hv, 4);
			r.column = c[COL_BITS-1:0];
			r.row    = ROW_BITS'(row_pos - 1);
			r.done   = 1'b0;
			pending_pixels.push_back(r);
		end
		if (last_row) begin
			r.pixel  = round_scale(newer + 2 * hv, 3);
			r.column = c[COL_BITS-1:0];
			r.row    = ROW_BITS'(row_pos);
			r.done   = last_img;
			pending_pixels.push_back(r);
		end
		hrow_older[c] = newer[HROW_BITS-1:0];
		hrow_newer[c] = hv[HROW_BITS-1:0];
	endfunction

	function automatic void blur_predict(logic [PIX_BITS-1:0] px);
		int unsigned     w;
		int unsigned     h;
		longint unsigned cur;
		longint unsigned hv;
		bit              last_col;
		bit              last_row;
		w = width_reg;
		h = height_reg;
		cur = px;
		if (w < 2) w = 2;
		if (w > MAX_W) w = MAX_W;
		if (h < 2) h = 2;
		last_col = col_pos >= w - 1;
		last_row = row_pos >= h - 1;
		if (col_pos >= 1) begin
			if (col_pos == 1)
				hv = ((2 * prev_px + cur) << FRAC) / 3;
			else
				hv = ((prev2_px + 2 * prev_px + cur) << FRAC) >> 2;
			take_hval(hv, col_pos - 1, last_row, 1'b0);
		end
		if (last_col) begin
			hv = ((prev_px + 2 * cur) << FRAC) / 3;
			take_hval(hv, col_pos, last_row, last_row);
		end
		prev2_px = prev_px;
		prev_px  = cur;
		if (last_col) begin
			col_pos  = 0;
			prev_px  = 0;
			prev2_px = 0;
			if (last_row) begin
				row_pos = 0;
				frame_closed = 1'b1;
				images_done++;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
	endfunction

	function automatic logic [PIX_BITS-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_BITS'($urandom_range(0, 65535));
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_pixel(input logic [PIX_BITS-1:0] px);
		int gap;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push     <= 1'b1;
		pixel_in <= px;
		forever begin
			@(posedge clk);
			if (full === 1'b0) break;
			full_stalls++;
		end
		pixels_sent++;
		blur_predict(px);
		@(negedge clk);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		@(negedge clk);
		while (pending_pixels.size() > 0) @(negedge clk);
	endtask

	// rows without results may still be in flight after the last result
	task automatic wait_idle();
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == CFG_WIDTH)
			width_reg = data[IW_BITS-1:0];
		else
			height_reg = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_frame(input logic [CFG_DATA_BITS-1:0] w,
			input logic [CFG_DATA_BITS-1:0] h);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		frame_closed = 1'b0;
	endtask

	task automatic run_to_close();
		while (!frame_closed) send_pixel(rand_pixel());
	endtask

	// smallest images, sizes below the minimum, and full-scale pixel values
	task automatic test_smallest_frames();
		logic [PIX_BITS-1:0] pat [9];
		pat = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
			16'hFFFF, 16'h0000, 16'hFFFF};
		set_frame(2, 2);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		set_frame(0, 1);
		for (int i = 0; i < 4; i++) send_pixel(pat[i + 1]);
		set_frame(1, 0);
		repeat (4) send_pixel(16'hFFFF);
		set_frame(3, 3);
		for (int i = 0; i < 9; i++) send_pixel(pat[i]);
	endtask

	task automatic test_wide_rows();
		set_frame(24, 2);
		run_to_close();
		// all data bits high: width masks to 2047 and clamps to the maximum;
		// narrow it to end the first row early
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		set_frame(16'hFFFF, 2);
		repeat (24) send_pixel(rand_pixel());
		write_reg(CFG_WIDTH, 6);
		run_to_close();
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	task automatic test_mid_frame_changes();
		// tallest setting, then cut the image short below the current row
		set_frame(16'hF802, 16'hFFFF);
		repeat (6) send_pixel(rand_pixel());
		write_reg(CFG_HEIGHT, 2);
		run_to_close();
		// narrow the first row past its current column
		set_frame(20, 4);
		repeat (12) send_pixel(rand_pixel());
		write_reg(CFG_WIDTH, 5);
		run_to_close();
		// widen the first row, then grow the height later on
		set_frame(4, 3);
		repeat (2) send_pixel(rand_pixel());
		write_reg(CFG_WIDTH, 9);
		repeat (10) send_pixel(rand_pixel());
		write_reg(CFG_HEIGHT, 6);
		run_to_close();
	endtask

	task automatic test_output_backpressure();
		set_frame(10, 5);
		rx_hold_cycles = HOLD_CYCLES;
		run_to_close();
		set_frame(7, 5);
		repeat (17) send_pixel(rand_pixel());
		drain_results();
		run_to_close();
	endtask

	task automatic test_random_frames();
		int                       start_count;
		logic [CFG_DATA_BITS-1:0] w;
		logic [CFG_DATA_BITS-1:0] h;
		start_count = pixels_sent;
		while (pixels_sent - start_count < RAND_PIXELS) begin
			case ($urandom_range(0, 19))
				0: w = CFG_DATA_BITS'($urandom_range(0, 1));
				1, 2: w = CFG_DATA_BITS'($urandom_range(13, 40));
				default: w = CFG_DATA_BITS'($urandom_range(2, 12));
			endcase
			// upper data bits are not part of the width
			if ($urandom_range(0, 3) == 0)
				w = w | (CFG_DATA_BITS'($urandom_range(1, 31)) << IW_BITS);
			h = ($urandom_range(0, 9) == 0) ? CFG_DATA_BITS'($urandom_range(0, 1)) :
				CFG_DATA_BITS'($urandom_range(2, 7));
			gaps_on   = $urandom_range(0, 5) != 0;
			stalls_on = $urandom_range(0, 5) != 0;
			set_frame(w, h);
			while (!frame_closed) begin
				if ($urandom_range(0, 60) == 0) drain_results();
				send_pixel(rand_pixel());
			end
		end
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	task automatic test_back_to_back();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		set_frame(8, 5);
		run_to_close();
		set_frame(2, 9);
		run_to_close();
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	// result side: random gaps plus an optional long hold
	initial begin
		int wait_n;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			wait_n = stalls_on ? $urandom_range(0, 3) : 0;
			wait_n += rx_hold_cycles;
			rx_hold_cycles = 0;
			if (wait_n > 0) begin
				pop <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		blur_result_t want;
		if (arst_n && pop && !empty) begin
			results_checked++;
			if (pending_pixels.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: pixel %h col %0d row %0d done %b",
						pixel_out, out_column, out_row, image_done);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_out !== want.pixel || out_column !== want.column ||
						out_row !== want.row || image_done !== want.done) begin
					if (mismatches < 10)
						$display({"mismatch: expected pixel %h col %0d row %0d done %b,",
							" got pixel %h col %0d row %0d done %b"},
							want.pixel, want.column, want.row, want.done,
							pixel_out, out_column, out_row, image_done);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_pixels.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = CFG_WIDTH;
		cfg_data        = '0;
		push            = 1'b0;
		pixel_in        = '0;
		gaps_on         = 1'b1;
		stalls_on       = 1'b1;
		rx_hold_cycles  = 0;
		cycle_count     = 0;
		pixels_sent     = 0;
		results_checked = 0;
		images_done     = 0;
		mismatches      = 0;
		full_stalls     = 0;
		width_reg       = WIDTH_RESET;
		height_reg      = HEIGHT_RESET;
		prev_px         = 0;
		prev2_px        = 0;
		col_pos         = 0;
		row_pos         = 0;
		frame_closed    = 1'b0;
		for (int i = 0; i < MAX_W; i++) begin
			hrow_older[i] = '0;
			hrow_newer[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_smallest_frames();
		test_wide_rows();
		test_mid_frame_changes();
		test_output_backpressure();
		test_random_frames();
		test_back_to_back();
		wait_idle();

		$display("Covered %0d pixels and %0d results over %0d images, small to wide sizes,",
			pixels_sent, results_checked, images_done);
		$display("with mid-image size changes, %0d input stalls under held output, %0d errors.",
			full_stalls, mismatches);
		if (mismatches == 0 && pending_pixels.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
